[hw/rtl/lbt_pkg.sv]
// ----------------------------------------------------------------------------
// lbt_pkg
// Shared constants, register indexes, cell control type and the divide-by-255
// helper for the LED bit-plane transposer.
// ----------------------------------------------------------------------------
package lbt_pkg;

  // matrix geometry
  localparam int unsigned ROWS      = 64;
  localparam int unsigned COLUMNS   = 32;
  localparam int unsigned BUSES     = 4;

  // fixed widths of the LED word and the lane word
  localparam int unsigned PLANES     = 24;
  localparam int unsigned LANES      = 32;
  localparam int unsigned BUS_SLOTS  = 4;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned COL_W      = 5;
  localparam int unsigned BIT_W      = 5;
  localparam int unsigned LANE_CNT_W = 6;
  localparam int unsigned OFFSET_W   = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [7:0] FULL_SCALE = 8'd255;
  localparam logic [LANE_CNT_W-1:0] LANES_RESET = LANE_CNT_W'(8);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_VERTICAL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_HORIZONTAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIRE_ORDER_RGB = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LANES_BUS0     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LANES_BUS1     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LANES_BUS2     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LANES_BUS3     = 3'd7;

  typedef struct packed {
    logic             set_en;
    logic             shift_en;
    logic [LANES-1:0] lane_mask;
  } lbt_cell_ctrl_t;

  // exact floor(x / 255) for x up to 255 * 254
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

endpackage

[hw/rtl/lbt_plane_cell.sv]
// ----------------------------------------------------------------------------
// lbt_plane_cell
// One bit-plane word: collects the pixel bit at its lane and hands the word
// to its neighbor while the row is shifted out.
// ----------------------------------------------------------------------------
module lbt_plane_cell
  import lbt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lbt_cell_ctrl_t   ctrl_i,
  input  logic             bit_i,
  input  logic [LANES-1:0] shift_in_i,
  output logic [LANES-1:0] plane_o
);

  logic [LANES-1:0] plane_q, plane_d;

  always_comb begin
    plane_d = plane_q;
    if (ctrl_i.shift_en) begin
      plane_d = shift_in_i;
    end else if (ctrl_i.set_en && bit_i) begin
      plane_d = plane_q | ctrl_i.lane_mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
    end else begin
      plane_q <= plane_d;
    end
  end

  assign plane_o = plane_q;

endmodule

[hw/rtl/lbt_bus_split.sv]
// ----------------------------------------------------------------------------
// lbt_bus_split
// Cuts one plane word into per-bus words by the configured lane counts.
// ----------------------------------------------------------------------------
module lbt_bus_split
  import lbt_pkg::*;
(
  input  logic [LANES-1:0]                      plane_i,
  input  logic [BUS_SLOTS-1:0][LANE_CNT_W-1:0]  lanes_i,
  output logic [BUS_SLOTS-1:0][LANES-1:0]       words_o
);

  logic [BUS_SLOTS-1:0][OFFSET_W-1:0] offs;
  logic [OFFSET_W-1:0]                acc;

  // running lane offset of each bus
  always_comb begin
    acc = '0;
    for (int b = 0; b < BUS_SLOTS; b++) begin
      offs[b] = acc;
      acc     = acc + OFFSET_W'(lanes_i[b]);
    end
  end

  for (genvar b = 0; b < BUS_SLOTS; b++) begin : g_bus
    if (b < BUSES) begin : g_present
      logic [LANES-1:0] mask;
      assign mask = (lanes_i[b] >= LANE_CNT_W'(LANES)) ? '1
                  : ((LANES'(1) << lanes_i[b][4:0]) - LANES'(1));
      assign words_o[b] = (offs[b] >= OFFSET_W'(LANES)) ? '0
                        : ((plane_i >> offs[b][4:0]) & mask);
    end else begin : g_absent
      assign words_o[b] = '0;
    end
  end

endmodule

[hw/rtl/led_bitplane_transposer.sv]
// ----------------------------------------------------------------------------
// led_bitplane_transposer
// Collects one matrix row of pixels into 24 bit planes and sends them out
// plane by plane, split into bus words for parallel LED strips.
// ----------------------------------------------------------------------------
// Usage: pixels of one row enter on the in channel (valid/ready), one per
// transfer. A pixel is accepted in one cycle and written into the row of 24
// plane cells in the next; the input is not ready again until it is written.
// Brightness is applied with one 8x8 multiply per channel, registered before
// the divide by 255. A pixel with row_done set starts emission: 24 results
// leave on the out channel (valid/ready) through an output register, bit 0
// first, one per cycle while the receiver is ready; the first is loaded
// after the row_done pixel is written. During emission the cells shift their
// words toward cell 0 and fill with zeros, so the planes are clear when the
// 24th result is loaded. If the receiver stalls, emission waits with the
// output register full; the next pixel can be accepted once the last plane
// is loaded, even before it is taken. Reset clears the planes and loads the
// register defaults (brightness 255, no flips, GRB order, 8 lanes per bus).
// Configuration goes in through cfg_we_i / cfg_index_i / cfg_data_i; the user
// must write it only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module led_bitplane_transposer
  import lbt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // pixel input
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [POS_W-1:0]      row_index_i,
  input  logic [COL_W-1:0]      column_index_i,
  input  logic [7:0]            red_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            blue_i,
  input  logic                  row_done_i,
  // plane output
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [POS_W-1:0]      strip_position_o,
  output logic [BIT_W-1:0]      bit_index_o,
  output logic [LANES-1:0]      bus0_word_o,
  output logic [LANES-1:0]      bus1_word_o,
  output logic [LANES-1:0]      bus2_word_o,
  output logic [LANES-1:0]      bus3_word_o,
  output logic                  plane_last_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam logic [POS_W-1:0] ROW_LAST   = POS_W'(ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST   = COL_W'(COLUMNS - 1);
  localparam logic [BIT_W-1:0] PLANE_LAST = BIT_W'(PLANES - 1);

  // configuration registers
  logic [7:0]                           brightness_q;
  logic                                 flip_v_q, flip_h_q, order_rgb_q;
  logic [BUS_SLOTS-1:0][LANE_CNT_W-1:0] lanes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= FULL_SCALE;
      flip_v_q     <= 1'b0;
      flip_h_q     <= 1'b0;
      order_rgb_q  <= 1'b0;
      lanes_q      <= {BUS_SLOTS{LANES_RESET}};
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_BRIGHTNESS:      brightness_q <= cfg_data_i;
        REG_FLIP_VERTICAL:   flip_v_q     <= cfg_data_i[0];
        REG_FLIP_HORIZONTAL: flip_h_q     <= cfg_data_i[0];
        REG_WIRE_ORDER_RGB:  order_rgb_q  <= cfg_data_i[0];
        REG_LANES_BUS0:      lanes_q[0]   <= cfg_data_i[LANE_CNT_W-1:0];
        REG_LANES_BUS1:      lanes_q[1]   <= cfg_data_i[LANE_CNT_W-1:0];
        REG_LANES_BUS2:      lanes_q[2]   <= cfg_data_i[LANE_CNT_W-1:0];
        REG_LANES_BUS3:      lanes_q[3]   <= cfg_data_i[LANE_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // control
  logic [1:0]       state_q, state_d;
  logic [BIT_W-1:0] emit_cnt_q, emit_cnt_d;
  logic             in_xfer, out_load;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_EMIT) && (!out_valid_o || out_ready_i);

  // accepted pixel
  logic                   done_q, pass_q;
  logic [POS_W-1:0]       pos_q;
  logic [LANES-1:0]       lane_mask_q;
  logic [2:0][7:0]        chan_q;
  logic [2:0][15:0]       prod_q;
  logic                   col_ok;
  logic [COL_W-1:0]       lane;

  assign col_ok = 32'(column_index_i) < COLUMNS;
  assign lane   = flip_h_q ? (COL_LAST - column_index_i) : column_index_i;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      done_q      <= row_done_i;
      pass_q      <= (brightness_q == FULL_SCALE);
      pos_q       <= flip_v_q ? (ROW_LAST - row_index_i) : row_index_i;
      lane_mask_q <= col_ok ? (LANES'(1) << lane) : '0;
      chan_q      <= {red_i, green_i, blue_i};
      prod_q[2]   <= 16'(red_i) * 16'(brightness_q);
      prod_q[1]   <= 16'(green_i) * 16'(brightness_q);
      prod_q[0]   <= 16'(blue_i) * 16'(brightness_q);
    end
  end

  // scaled channels and the 24-bit led word
  logic [2:0][7:0]   scaled;
  logic [PLANES-1:0] pix_word;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      scaled[c] = pass_q ? chan_q[c] : div255(prod_q[c]);
    end
    // index 2 red, 1 green, 0 blue
    pix_word = order_rgb_q ? {scaled[2], scaled[1], scaled[0]}
                           : {scaled[1], scaled[2], scaled[0]};
  end

  // row of plane cells, cell 0 holds plane 0 and feeds the output
  lbt_cell_ctrl_t                     cell_ctrl;
  logic [PLANES-1:0][LANES-1:0]       plane_q;

  assign cell_ctrl.set_en    = (state_q == ST_UPD);
  assign cell_ctrl.shift_en  = out_load;
  assign cell_ctrl.lane_mask = lane_mask_q;

  for (genvar k = 0; k < PLANES; k++) begin : g_cell
    logic [LANES-1:0] shift_in;
    if (k == PLANES - 1) begin : g_top
      assign shift_in = '0;
    end else begin : g_mid
      assign shift_in = plane_q[k+1];
    end
    lbt_plane_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .bit_i      (pix_word[PLANES-1-k]),
      .shift_in_i (shift_in),
      .plane_o    (plane_q[k])
    );
  end

  logic [BUS_SLOTS-1:0][LANES-1:0] split_words;

  lbt_bus_split u_split (
    .plane_i (plane_q[0]),
    .lanes_i (lanes_q),
    .words_o (split_words)
  );

  // state machine
  always_comb begin
    state_d    = state_q;
    emit_cnt_d = emit_cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = ST_UPD;
      end
      ST_UPD: begin
        emit_cnt_d = '0;
        state_d    = done_q ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_load) begin
          emit_cnt_d = emit_cnt_q + BIT_W'(1);
          if (emit_cnt_q == PLANE_LAST) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      emit_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      emit_cnt_q <= emit_cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output register
  logic [POS_W-1:0]                pos_out_q;
  logic [BIT_W-1:0]                bit_out_q;
  logic                            last_out_q;
  logic [BUS_SLOTS-1:0][LANES-1:0] words_out_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pos_out_q   <= pos_q;
      bit_out_q   <= emit_cnt_q;
      last_out_q  <= (emit_cnt_q == PLANE_LAST);
      words_out_q <= split_words;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign strip_position_o = pos_out_q;
  assign bit_index_o      = bit_out_q;
  assign plane_last_o     = last_out_q;
  assign bus0_word_o      = words_out_q[0];
  assign bus1_word_o      = words_out_q[1];
  assign bus2_word_o      = words_out_q[2];
  assign bus3_word_o      = words_out_q[3];

  // the last plane carries the top plane index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && plane_last_o |-> bit_index_o == PLANE_LAST)
    else $error("plane_last on wrong plane index");

  // planes are all clear once the last one is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && (emit_cnt_q == PLANE_LAST) |=> plane_q == '0)
    else $error("planes not cleared after emission");

  // a taken plane that is not the last is followed by the next plane
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !plane_last_o
    |=> out_valid_o && bit_index_o == $past(bit_index_o) + BIT_W'(1))
    else $error("plane sequence broken");

  // no pixel is taken while planes are being sent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && (emit_cnt_q != PLANE_LAST) |=> !in_ready_o)
    else $error("input opened during emission");

endmodule
